FILE: rtl/biquad_and_ladder_filter_unit_macros.svh
// Assertion macros for the biquad / ladder filter unit.
// Used by the top level only; the bodies drop out when NO_ASSERTIONS is defined.
`ifndef BIQUAD_AND_LADDER_FILTER_UNIT_MACROS_SVH
`define BIQUAD_AND_LADDER_FILTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent
`define BLF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BLF_ASSERT_SAME(label, ante, cons, msg)
`define BLF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/blf_pkg.sv
// Shared types and fixed constants of the biquad / ladder filter unit.
// No dependencies; used by blf_mac and biquad_and_ladder_filter_unit.
package blf_pkg;

    // Multiplier digit: bits of operand B consumed per cycle
    localparam int MUL_DIGIT = 16;

    // Ladder depth and sequencer sizes
    localparam int LAD_STAGES  = 4;
    localparam int OP_WIDTH    = 4;
    localparam logic [OP_WIDTH-1:0] BIQ_LAST_OP = 4'd4;
    localparam logic [OP_WIDTH-1:0] LAD_LAST_OP = 4'd11;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_B0       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_B1       = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_B2       = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_A1       = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_A2       = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FEEDBACK = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POLE     = 3'd7;

    // Filter modes
    localparam logic MODE_BIQUAD = 1'b0;
    localparam logic MODE_LADDER = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } state_t;

    // Accumulator setup when a multiply starts
    typedef enum logic [1:0] {
        INIT_KEEP,
        INIT_ZERO,
        INIT_SAMPLE
    } acc_init_t;

    // Operand A sources
    typedef enum logic [3:0] {
        A_B0,
        A_B1,
        A_B2,
        A_A1,
        A_A2,
        A_FEEDBACK,
        A_SUM,
        A_GAIN,
        A_Y,
        A_CUBE
    } a_sel_t;

    // Operand B sources
    typedef enum logic [3:0] {
        B_X,
        B_XH0,
        B_XH1,
        B_YH0,
        B_YH1,
        B_STAGE,
        B_POLE,
        B_Y,
        B_SIXTH
    } b_sel_t;

    // Action taken once the accumulator is settled
    typedef enum logic [2:0] {
        POST_NONE,
        POST_BIQ_OUT,
        POST_LAD_U,
        POST_LAD_STAGE,
        POST_SHAPE_C,
        POST_SHAPE_OUT
    } post_t;

    // Decoded micro-op
    typedef struct packed {
        a_sel_t    a_sel;
        b_sel_t    b_sel;
        logic      neg_a;
        acc_init_t acc_init;
        post_t     post;
    } op_ctrl_t;

    // Command from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic      start;
        acc_init_t init;
    } mac_cmd_t;

endpackage

FILE: rtl/blf_mac.sv
// Digit-serial multiply-accumulate unit shared by all filter products.
// Depends on blf_pkg (MUL_DIGIT, mac_cmd_t, acc_init_t).
module blf_mac #(
    parameter int A_WIDTH    = 40,
    parameter int B_WIDTH    = 32,
    parameter int ACC_WIDTH  = 75,
    parameter int INIT_SHIFT = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  blf_pkg::mac_cmd_t           cmd,
    input  logic signed [A_WIDTH-1:0]   op_a,
    input  logic signed [B_WIDTH-1:0]   op_b,
    input  logic signed [B_WIDTH-1:0]   init_sample,
    output logic                        busy,
    output logic signed [ACC_WIDTH-1:0] acc
);

    localparam int D   = blf_pkg::MUL_DIGIT;
    localparam int NCH = (B_WIDTH + D - 1) / D;
    localparam int BW  = NCH * D;
    localparam int PW  = A_WIDTH + BW;
    localparam int CW  = $clog2(NCH + 1);

    logic signed [A_WIDTH-1:0]   a_reg;
    logic        [BW-1:0]        b_reg;
    logic signed [PW-1:0]        prod_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;
    logic        [CW-1:0]        cnt_reg;
    logic                        add_reg;

    logic        [D-1:0]         chunk;
    logic                        first_digit;
    logic signed [D:0]           chunk_s;
    logic signed [A_WIDTH+D:0]   pp;
    logic signed [PW-1:0]        prod_next;
    logic signed [ACC_WIDTH-1:0] acc_next;
    logic signed [ACC_WIDTH-1:0] acc_init_val;

    // Top digit of B, signed only for the most significant one
    assign chunk       = b_reg[BW-1 -: D];
    assign first_digit = (cnt_reg == CW'(NCH));
    assign chunk_s     = {first_digit & chunk[D-1], chunk};
    assign pp          = a_reg * chunk_s;
    assign prod_next   = (prod_reg <<< D) + PW'(pp);

    // Accumulator value on the start edge
    assign acc_init_val = ACC_WIDTH'(init_sample) <<< INIT_SHIFT;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.start)
        begin
            unique case (cmd.init)
                blf_pkg::INIT_ZERO:   acc_next = '0;
                blf_pkg::INIT_SAMPLE: acc_next = acc_init_val;
                default:              acc_next = acc_reg;
            endcase
        end
        else if (add_reg)
        begin
            acc_next = acc_reg + ACC_WIDTH'(prod_reg);
        end
    end

    // Digit counter and final add flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            add_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            cnt_reg <= CW'(NCH);
            add_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            add_reg <= (cnt_reg == CW'(1));
        end
        else
        begin
            add_reg <= 1'b0;
        end
    end

    // Operands, partial product and accumulator
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (cmd.start)
        begin
            a_reg    <= op_a;
            b_reg    <= BW'(op_b);
            prod_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            b_reg    <= b_reg << D;
            prod_reg <= prod_next;
        end
    end

    assign busy = (cnt_reg != '0) || add_reg;
    assign acc  = acc_reg;

endmodule

FILE: rtl/biquad_and_ladder_filter_unit.sv
// Biquad / four-stage resonant ladder filter, one sample in, one sample out.
// Depends on blf_pkg, blf_mac and biquad_and_ladder_filter_unit_macros.svh.
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-----------------------------
//  s_axis    | in        | s_axis_tvalid/tready     | tdata: sample_in
//  m_axis    | out       | m_axis_tvalid/tready     | tdata: sample_out
//  cfg       | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// Every product runs through one digit-serial multiplier (16 bits of B per cycle),
// N = ceil(SAMPLE_WIDTH/16) digits; each product passes through issue, the digit
// steps, final add and write-back in turn. s_axis_tready is high only while idle.
// Reset sets b0 to 1.0 and clears the other configuration, the filter history and
// ladder state; no clearing pass. A finished sample waits in the output register;
// the next item is taken meanwhile and only its write-back stalls until m_axis has
// room.
`include "biquad_and_ladder_filter_unit_macros.svh"

module biquad_and_ladder_filter_unit #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int FRAC_BITS    = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // sample_in in [SAMPLE_WIDTH-1:0], zero padded to whole bytes
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample_out in [SAMPLE_WIDTH-1:0], zero padded to whole bytes
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [blf_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [SAMPLE_WIDTH-1:0]                cfg_data
);

    localparam int TDW  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int D    = blf_pkg::MUL_DIGIT;
    localparam int NCH  = (SAMPLE_WIDTH + D - 1) / D;
    localparam int AW   = (SAMPLE_WIDTH + 2 > FRAC_BITS + 14) ? SAMPLE_WIDTH + 2
                                                              : FRAC_BITS + 14;
    localparam int ACCW = AW + NCH * D + 3;
    localparam int SW   = ACCW - FRAC_BITS;
    localparam int KW   = SAMPLE_WIDTH + 2;

    localparam logic signed [SW-1:0] S_MAX      = (SW'(1) <<< (SAMPLE_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] S_MIN      = -S_MAX - SW'(1);
    localparam logic signed [SW-1:0] Q_TEN      = SW'(10) <<< FRAC_BITS;
    localparam logic signed [SW-1:0] Q_TEN_NEG  = -Q_TEN;
    localparam logic signed [KW-1:0] Q_ONE_K    = KW'(1) <<< FRAC_BITS;
    localparam logic [SAMPLE_WIDTH-1:0] Q_SIXTH =
        SAMPLE_WIDTH'(((64'd1 << FRAC_BITS) + 64'd3) / 64'd6);

    // Saturate a wide signed value to the sample width
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [SAMPLE_WIDTH-1:0] r;
        priority if (v > S_MAX)
            r = S_MAX[SAMPLE_WIDTH-1:0];
        else if (v < S_MIN)
            r = S_MIN[SAMPLE_WIDTH-1:0];
        else
            r = v[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

    // Sequencer
    blf_pkg::state_t                  state_reg, state_next;
    logic [blf_pkg::OP_WIDTH-1:0]     op_reg, op_next;
    logic [blf_pkg::OP_WIDTH-1:0]     op_m1;
    logic [1:0]                       lidx;
    blf_pkg::op_ctrl_t                op_ctrl;
    logic                             op_final;
    logic                             post_go;
    logic                             out_free;

    // Configuration
    logic                             mode_reg;
    logic signed [SAMPLE_WIDTH-1:0]   coef_b0_reg, coef_b1_reg, coef_b2_reg;
    logic signed [SAMPLE_WIDTH-1:0]   coef_a1_reg, coef_a2_reg;
    logic signed [SAMPLE_WIDTH-1:0]   ladder_feedback_reg, ladder_pole_reg;

    // Filter state
    logic signed [SAMPLE_WIDTH-1:0]   xh_reg [2];
    logic signed [SAMPLE_WIDTH-1:0]   yh_reg [2];
    logic signed [SAMPLE_WIDTH-1:0]   stage_reg [blf_pkg::LAD_STAGES];
    logic signed [SAMPLE_WIDTH-1:0]   prev_reg [blf_pkg::LAD_STAGES];

    // Per-item working registers
    logic signed [SAMPLE_WIDTH-1:0]   x_reg;
    logic signed [SAMPLE_WIDTH-1:0]   k_reg;
    logic signed [SAMPLE_WIDTH-1:0]   u_reg;
    logic signed [AW-1:0]             c_reg;
    logic        [SAMPLE_WIDTH-1:0]   out_data_reg;
    logic                             out_valid_reg;

    // Datapath
    blf_pkg::mac_cmd_t                mac_cmd;
    logic                             mac_busy;
    logic signed [ACCW-1:0]           mac_acc;
    logic signed [AW-1:0]             a_raw, a_op;
    logic signed [SAMPLE_WIDTH-1:0]   b_op;
    logic signed [SW-1:0]             scaled;
    logic signed [SAMPLE_WIDTH-1:0]   scaled_sat;
    logic signed [SAMPLE_WIDTH-1:0]   y_clamped;
    logic signed [SAMPLE_WIDTH-1:0]   shape_out;
    logic signed [KW-1:0]             k_wide;
    logic signed [SAMPLE_WIDTH-1:0]   k_sat;
    logic signed [SW-1:0]             stage3_ext;
    logic                             stage3_in_range;
    logic                             in_accept;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Ladder stage index: last stage for the feedback product, else (op-1)/2
    assign op_m1 = op_reg - blf_pkg::OP_WIDTH'(1);
    assign lidx  = (op_reg == '0) ? 2'd3 : op_m1[2:1];

    // Micro-op decode
    always_comb
    begin
        op_ctrl = '{a_sel: blf_pkg::A_B0, b_sel: blf_pkg::B_X, neg_a: 1'b0,
                    acc_init: blf_pkg::INIT_ZERO, post: blf_pkg::POST_NONE};
        if (mode_reg == blf_pkg::MODE_BIQUAD)
        begin
            unique case (op_reg)
                4'd0: op_ctrl = '{blf_pkg::A_B0, blf_pkg::B_X, 1'b0,
                                  blf_pkg::INIT_ZERO, blf_pkg::POST_NONE};
                4'd1: op_ctrl = '{blf_pkg::A_B1, blf_pkg::B_XH0, 1'b0,
                                  blf_pkg::INIT_KEEP, blf_pkg::POST_NONE};
                4'd2: op_ctrl = '{blf_pkg::A_B2, blf_pkg::B_XH1, 1'b0,
                                  blf_pkg::INIT_KEEP, blf_pkg::POST_NONE};
                4'd3: op_ctrl = '{blf_pkg::A_A1, blf_pkg::B_YH0, 1'b1,
                                  blf_pkg::INIT_KEEP, blf_pkg::POST_NONE};
                4'd4: op_ctrl = '{blf_pkg::A_A2, blf_pkg::B_YH1, 1'b1,
                                  blf_pkg::INIT_KEEP, blf_pkg::POST_BIQ_OUT};
                default: op_ctrl = '{blf_pkg::A_B0, blf_pkg::B_X, 1'b0,
                                     blf_pkg::INIT_ZERO, blf_pkg::POST_BIQ_OUT};
            endcase
        end
        else
        begin
            unique case (op_reg)
                4'd0: op_ctrl = '{blf_pkg::A_FEEDBACK, blf_pkg::B_STAGE, 1'b1,
                                  blf_pkg::INIT_SAMPLE, blf_pkg::POST_LAD_U};
                4'd1, 4'd3, 4'd5, 4'd7:
                      op_ctrl = '{blf_pkg::A_SUM, blf_pkg::B_POLE, 1'b0,
                                  blf_pkg::INIT_ZERO, blf_pkg::POST_NONE};
                4'd2, 4'd4, 4'd6, 4'd8:
                      op_ctrl = '{blf_pkg::A_GAIN, blf_pkg::B_STAGE, 1'b1,
                                  blf_pkg::INIT_KEEP, blf_pkg::POST_LAD_STAGE};
                4'd9: op_ctrl = '{blf_pkg::A_Y, blf_pkg::B_Y, 1'b0,
                                  blf_pkg::INIT_ZERO, blf_pkg::POST_SHAPE_C};
                4'd10: op_ctrl = '{blf_pkg::A_CUBE, blf_pkg::B_Y, 1'b0,
                                   blf_pkg::INIT_ZERO, blf_pkg::POST_SHAPE_C};
                4'd11: op_ctrl = '{blf_pkg::A_CUBE, blf_pkg::B_SIXTH, 1'b0,
                                   blf_pkg::INIT_ZERO, blf_pkg::POST_SHAPE_OUT};
                default: op_ctrl = '{blf_pkg::A_Y, blf_pkg::B_SIXTH, 1'b0,
                                     blf_pkg::INIT_ZERO, blf_pkg::POST_SHAPE_OUT};
            endcase
        end
    end

    assign op_final = (op_ctrl.post == blf_pkg::POST_BIQ_OUT) ||
                      (op_ctrl.post == blf_pkg::POST_SHAPE_OUT);

    // Operand A select, then optional negation for subtracted terms
    always_comb
    begin
        unique case (op_ctrl.a_sel)
            blf_pkg::A_B0:       a_raw = AW'(coef_b0_reg);
            blf_pkg::A_B1:       a_raw = AW'(coef_b1_reg);
            blf_pkg::A_B2:       a_raw = AW'(coef_b2_reg);
            blf_pkg::A_A1:       a_raw = AW'(coef_a1_reg);
            blf_pkg::A_A2:       a_raw = AW'(coef_a2_reg);
            blf_pkg::A_FEEDBACK: a_raw = AW'(ladder_feedback_reg);
            blf_pkg::A_SUM:      a_raw = AW'(u_reg) + AW'(prev_reg[lidx]);
            blf_pkg::A_GAIN:     a_raw = AW'(k_reg);
            blf_pkg::A_Y:        a_raw = AW'(u_reg);
            blf_pkg::A_CUBE:     a_raw = c_reg;
            default:             a_raw = '0;
        endcase
        a_op = op_ctrl.neg_a ? -a_raw : a_raw;
    end

    // Operand B select
    always_comb
    begin
        unique case (op_ctrl.b_sel)
            blf_pkg::B_X:     b_op = x_reg;
            blf_pkg::B_XH0:   b_op = xh_reg[0];
            blf_pkg::B_XH1:   b_op = xh_reg[1];
            blf_pkg::B_YH0:   b_op = yh_reg[0];
            blf_pkg::B_YH1:   b_op = yh_reg[1];
            blf_pkg::B_STAGE: b_op = stage_reg[lidx];
            blf_pkg::B_POLE:  b_op = ladder_pole_reg;
            blf_pkg::B_Y:     b_op = u_reg;
            blf_pkg::B_SIXTH: b_op = Q_SIXTH;
            default:          b_op = '0;
        endcase
    end

    // Shared multiply-accumulate unit
    blf_mac #(
        .A_WIDTH    (AW),
        .B_WIDTH    (SAMPLE_WIDTH),
        .ACC_WIDTH  (ACCW),
        .INIT_SHIFT (FRAC_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (mac_cmd),
        .op_a        (a_op),
        .op_b        (b_op),
        .init_sample (x_reg),
        .busy        (mac_busy),
        .acc         (mac_acc)
    );

    // Write-back arithmetic: floor shift, saturate, clamp, shaper output
    assign scaled     = mac_acc[ACCW-1:FRAC_BITS];
    assign scaled_sat = sat_w(scaled);
    always_comb
    begin
        priority if (SW'(scaled_sat) > Q_TEN)
            y_clamped = Q_TEN[SAMPLE_WIDTH-1:0];
        else if (SW'(scaled_sat) < Q_TEN_NEG)
            y_clamped = Q_TEN_NEG[SAMPLE_WIDTH-1:0];
        else
            y_clamped = scaled_sat;
    end
    assign shape_out = sat_w(SW'(u_reg) - scaled);

    // Stage gain k = 2p - 1, saturated
    assign k_wide = (KW'(ladder_pole_reg) <<< 1) - Q_ONE_K;
    assign k_sat  = sat_w(SW'(k_wide));

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            blf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = blf_pkg::ST_ISSUE;
                    op_next    = '0;
                end
            end
            blf_pkg::ST_ISSUE:
            begin
                state_next = blf_pkg::ST_WAIT;
            end
            blf_pkg::ST_WAIT:
            begin
                if (post_go)
                begin
                    state_next = op_final ? blf_pkg::ST_IDLE : blf_pkg::ST_ISSUE;
                    op_next    = op_reg + blf_pkg::OP_WIDTH'(1);
                end
            end
            default:
            begin
                state_next = blf_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        mac_cmd       = '{start: 1'b0, init: blf_pkg::INIT_KEEP};
        post_go       = 1'b0;
        unique case (state_reg)
            blf_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            blf_pkg::ST_ISSUE:
            begin
                mac_cmd = '{start: 1'b1, init: op_ctrl.acc_init};
            end
            blf_pkg::ST_WAIT:
            begin
                post_go = !mac_busy && (!op_final || out_free);
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= blf_pkg::ST_IDLE;
            op_reg              <= '0;
            out_valid_reg       <= 1'b0;
            mode_reg            <= blf_pkg::MODE_BIQUAD;
            coef_b0_reg         <= SAMPLE_WIDTH'(Q_ONE_K);
            coef_b1_reg         <= '0;
            coef_b2_reg         <= '0;
            coef_a1_reg         <= '0;
            coef_a2_reg         <= '0;
            ladder_feedback_reg <= '0;
            ladder_pole_reg     <= '0;
            xh_reg[0]           <= '0;
            xh_reg[1]           <= '0;
            yh_reg[0]           <= '0;
            yh_reg[1]           <= '0;
            for (int i = 0; i < blf_pkg::LAD_STAGES; i++)
            begin
                stage_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;

            // Output register: cleared when taken, loaded by the last write-back
            if (post_go && op_final)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            // Configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    blf_pkg::CFG_MODE:     mode_reg            <= cfg_data[0];
                    blf_pkg::CFG_B0:       coef_b0_reg         <= cfg_data;
                    blf_pkg::CFG_B1:       coef_b1_reg         <= cfg_data;
                    blf_pkg::CFG_B2:       coef_b2_reg         <= cfg_data;
                    blf_pkg::CFG_A1:       coef_a1_reg         <= cfg_data;
                    blf_pkg::CFG_A2:       coef_a2_reg         <= cfg_data;
                    blf_pkg::CFG_FEEDBACK: ladder_feedback_reg <= cfg_data;
                    blf_pkg::CFG_POLE:     ladder_pole_reg     <= cfg_data;
                    default:               mode_reg            <= mode_reg;
                endcase
            end

            // History and ladder state updates
            if (post_go)
            begin
                if (op_ctrl.post == blf_pkg::POST_BIQ_OUT)
                begin
                    xh_reg[1] <= xh_reg[0];
                    xh_reg[0] <= x_reg;
                    yh_reg[1] <= yh_reg[0];
                    yh_reg[0] <= scaled_sat;
                end
                if (op_ctrl.post == blf_pkg::POST_LAD_STAGE)
                begin
                    prev_reg[lidx]  <= u_reg;
                    stage_reg[lidx] <= y_clamped;
                end
            end
        end
    end

    // Per-item working values
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= $signed(s_axis_tdata[SAMPLE_WIDTH-1:0]);
            k_reg <= k_sat;
        end
        if (post_go)
        begin
            unique case (op_ctrl.post)
                blf_pkg::POST_BIQ_OUT:   out_data_reg <= scaled_sat;
                blf_pkg::POST_LAD_U:     u_reg        <= scaled_sat;
                blf_pkg::POST_LAD_STAGE: u_reg        <= y_clamped;
                blf_pkg::POST_SHAPE_C:   c_reg        <= scaled[AW-1:0];
                blf_pkg::POST_SHAPE_OUT: out_data_reg <= shape_out;
                default:                 c_reg        <= c_reg;
            endcase
        end
    end

    assign m_axis_tdata  = TDW'(out_data_reg);
    assign m_axis_tvalid = out_valid_reg;
    assign cfg_ready     = 1'b1;

    // Last ladder stage must stay inside the clamp window
    assign stage3_ext      = SW'(stage_reg[3]);
    assign stage3_in_range = (stage3_ext <= Q_TEN) && (stage3_ext >= Q_TEN_NEG);

    `BLF_ASSERT_SAME(a_ready_mac_idle, s_axis_tready, !mac_busy, "item taken while MAC busy")
    `BLF_ASSERT_NEXT(a_one_item_at_once, in_accept, !s_axis_tready, "ready right after accept")
    `BLF_ASSERT_SAME(a_stage_clamped, 1'b1, stage3_in_range, "ladder stage out of clamp range")
    `BLF_ASSERT_SAME(a_out_from_wait, $rose(m_axis_tvalid), $past(state_reg == blf_pkg::ST_WAIT), "result loaded outside write-back")

endmodule

FILE: tb/biquad_and_ladder_filter_unit_tb.sv
// Self-checking testbench for biquad_and_ladder_filter_unit.
// Holds its own bit-exact filter predictor and needs only blf_pkg and the RTL.
// Directed corner cases, then random biquad/ladder runs under idling and stalls.
module biquad_and_ladder_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blf_pkg::*;

    localparam int  DATA_W       = 32;
    localparam int  FRAC         = 24;
    localparam int  LIMIT_CYCLES = 1_000_000;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  DRAIN_CYCLES = 100;
    localparam int  PHASE_ITEMS  = 112;

    // Q8.24 constants in raw bus form
    localparam logic [DATA_W-1:0] Q_ONE  = 32'h0100_0000;
    localparam logic [DATA_W-1:0] S_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S_MIN  = 32'h8000_0000;

    // Constants of the predictor
    localparam logic signed [127:0] WIDE_MAX = 128'sd2147483647;
    localparam logic signed [127:0] WIDE_MIN = -128'sd2147483648;
    localparam logic signed [127:0] W_ONE    = 128'sd16777216;
    localparam logic signed [127:0] W_SIXTH  = 128'sd2796203;
    localparam logic signed [31:0]  Q_TEN    = 32'sd167772160;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5ns clk = ~clk;

    // DUT ports
    logic [DATA_W-1:0]          s_axis_tdata  = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [DATA_W-1:0]          m_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index     = '0;
    logic [DATA_W-1:0]          cfg_data      = '0;

    biquad_and_ladder_filter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] sample_in
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] sample_out
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Stimulus and checking bookkeeping
    logic [DATA_W-1:0]        sample_feed_q[$];
    logic signed [DATA_W-1:0] expected_out_q[$];
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    int   hold_req       = 0;
    int   hold_ack       = 0;
    int   hold_left      = 0;
    int   error_count    = 0;
    int   cycle_count    = 0;
    logic in_fired       = 1'b0;

    // Predictor copy of the registers (reset values)
    logic                     filt_mode = MODE_BIQUAD;
    logic signed [DATA_W-1:0] gain_b0   = 32'sd16777216;
    logic signed [DATA_W-1:0] gain_b1   = '0;
    logic signed [DATA_W-1:0] gain_b2   = '0;
    logic signed [DATA_W-1:0] gain_a1   = '0;
    logic signed [DATA_W-1:0] gain_a2   = '0;
    logic signed [DATA_W-1:0] res_gain  = '0;
    logic signed [DATA_W-1:0] pole_p    = '0;

    // Predictor copy of the filter state
    logic signed [DATA_W-1:0] lad_y[4]    = '{default: '0};
    logic signed [DATA_W-1:0] lad_prev[4] = '{default: '0};
    logic signed [DATA_W-1:0] x_hist[2]   = '{default: '0};
    logic signed [DATA_W-1:0] y_hist[2]   = '{default: '0};

    function automatic logic signed [127:0] wide(input logic signed [63:0] v);
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [127:0] v);
        if (v > WIDE_MAX)
            return S_MAX;
        if (v < WIDE_MIN)
            return S_MIN;
        return v[DATA_W-1:0];
    endfunction

    function automatic void load_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                          input logic [DATA_W-1:0] val);
        case (idx)
            CFG_MODE:     filt_mode = val[0];
            CFG_B0:       gain_b0   = val;
            CFG_B1:       gain_b1   = val;
            CFG_B2:       gain_b2   = val;
            CFG_A1:       gain_a1   = val;
            CFG_A2:       gain_a2   = val;
            CFG_FEEDBACK: res_gain  = val;
            CFG_POLE:     pole_p    = val;
            default:      ;
        endcase
    endfunction

    // One sample through the filter; updates the predictor state
    function automatic logic signed [DATA_W-1:0] filter_sample(input logic [DATA_W-1:0] raw);
        logic signed [127:0]      acc;
        logic signed [DATA_W-1:0] x, k, u, y, res;
        logic signed [63:0]       c;
        x = raw;
        if (filt_mode == MODE_LADDER) begin
            k   = sat_q(wide(pole_p) * 2 - W_ONE);
            acc = wide(x) * W_ONE - wide(res_gain) * wide(lad_y[3]);
            acc = acc >>> FRAC;
            u   = sat_q(acc);
            for (int i = 0; i < LAD_STAGES; i++) begin
                acc = (wide(u) + wide(lad_prev[i])) * wide(pole_p) - wide(k) * wide(lad_y[i]);
                acc = acc >>> FRAC;
                y   = sat_q(acc);
                if (y > Q_TEN)
                    y = Q_TEN;
                if (y < -Q_TEN)
                    y = -Q_TEN;
                lad_prev[i] = u;
                lad_y[i]    = y;
                u           = y;
            end
            // cubic shaper y - y^3/6, intermediate products kept to 64 bits
            y   = lad_y[3];
            acc = wide(y) * wide(y);
            acc = acc >>> FRAC;
            c   = acc[63:0];
            acc = wide(c) * wide(y);
            acc = acc >>> FRAC;
            c   = acc[63:0];
            acc = wide(c) * W_SIXTH;
            acc = acc >>> FRAC;
            c   = acc[63:0];
            res = sat_q(wide(y) - wide(c));
        end
        else begin
            acc = wide(gain_b0) * wide(x) + wide(gain_b1) * wide(x_hist[0])
                + wide(gain_b2) * wide(x_hist[1]) - wide(gain_a1) * wide(y_hist[0])
                - wide(gain_a2) * wide(y_hist[1]);
            acc = acc >>> FRAC;
            res = sat_q(acc);
            x_hist[1] = x_hist[0];
            x_hist[0] = x;
            y_hist[1] = y_hist[0];
            y_hist[0] = res;
        end
        return res;
    endfunction

    // Random sample: extremes, full range, or mostly audio-sized values
    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return S_MAX;
                    1:       return S_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return $urandom();
            default: return $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
        endcase
    endfunction

    // Random coefficient: mostly in [lo, hi], sometimes an extreme or any value
    function automatic logic [DATA_W-1:0] rand_coef(input logic [DATA_W-1:0] lo,
                                                    input logic [DATA_W-1:0] hi);
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
            1:       return $urandom();
            default: return $urandom_range(0, hi - lo) + lo;
        endcase
    endfunction

    // Input driver: next item from the feed queue, with random gaps
    always @(negedge clk) begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_fired) begin
            if (sample_feed_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                s_axis_tdata  <= sample_feed_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Output side ready: random stalls plus requested long hold-offs
    always @(negedge clk) begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Monitor: tracks register writes, predicts accepted items, checks results
    always @(posedge clk) begin : monitor
        logic signed [DATA_W-1:0] want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
        in_fired <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                load_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                expected_out_q.push_back(filter_sample(s_axis_tdata[DATA_W-1:0]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_out_q.size() == 0) begin
                    $error("sample_out: no item expected, got %h", m_axis_tdata[DATA_W-1:0]);
                    error_count <= error_count + 1;
                end
                else begin
                    want = expected_out_q.pop_front();
                    if (m_axis_tdata[DATA_W-1:0] !== want) begin
                        $error("sample_out: expected %h, actual %h",
                               want, m_axis_tdata[DATA_W-1:0]);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    // Wait until every queued item is in and every result is out
    task automatic wait_drained();
        while (sample_feed_q.size() != 0 || s_axis_tvalid || expected_out_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mode write with random junk above bit 0
    task automatic set_mode(input logic m);
        logic [DATA_W-1:0] v;
        v    = $urandom();
        v[0] = m;
        write_reg(CFG_MODE, v);
    endtask

    task automatic program_biquad(input logic [DATA_W-1:0] b0, b1, b2, a1, a2);
        wait_drained();
        set_mode(MODE_BIQUAD);
        write_reg(CFG_B0, b0);
        write_reg(CFG_B1, b1);
        write_reg(CFG_B2, b2);
        write_reg(CFG_A1, a1);
        write_reg(CFG_A2, a2);
    endtask

    task automatic program_ladder(input logic [DATA_W-1:0] fb, p);
        wait_drained();
        set_mode(MODE_LADDER);
        write_reg(CFG_FEEDBACK, fb);
        write_reg(CFG_POLE, p);
    endtask

    // Main sequence
    initial begin : stimulus
        logic ladder_phase;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset coefficients pass samples straight through
        sample_feed_q = '{S_MAX, S_MIN, '0, '1, 32'h0000_0001, Q_ONE};

        // Biquad with extreme coefficients: saturation both ways
        program_biquad(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN);
        sample_feed_q = '{S_MAX, S_MIN, S_MAX, '0};

        // Ladder at unity pole with strong feedback: stage clamps and shaper
        program_ladder(4 * Q_ONE, Q_ONE);
        sample_feed_q = '{S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN};

        // Ladder with extreme registers: stage gain saturates
        program_ladder(S_MIN, S_MAX);
        sample_feed_q = '{Q_ONE, -Q_ONE, '0};

        // Back to biquad: its history survived the ladder run
        program_biquad('0, Q_ONE, Q_ONE, '0, '0);
        sample_feed_q = '{32'h0000_0001, '1, Q_ONE};

        // Random phases; mode and idling profile vary independently
        for (int ph = 0; ph < 8; ph++) begin
            ladder_phase = ph[0] ^ ph[2];
            if (ladder_phase)
                program_ladder(rand_coef('0, 4 * Q_ONE), rand_coef('0, Q_ONE));
            else
                program_biquad(rand_coef(-2 * Q_ONE, 2 * Q_ONE),
                               rand_coef(-2 * Q_ONE, 2 * Q_ONE),
                               rand_coef(-2 * Q_ONE, 2 * Q_ONE),
                               rand_coef(-2 * Q_ONE, 2 * Q_ONE),
                               rand_coef(-Q_ONE, Q_ONE));
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                sample_feed_q.push_back(rand_sample());
            // long output hold-off while the sender keeps going
            if (ph % 4 == 0)
                hold_req = hold_req + 1;
        end

        // Drain, settle, report
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_out_q.size() != 0) begin
            $error("sample_out: %0d expected items never arrived", expected_out_q.size());
            error_count = error_count + 1;
        end
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
